FILE: src/tsf_pkg.sv
// ----------------------------------------------------------------------------
// tsf_pkg
// Shared types and constants for the four-policy task scheduler.
// ----------------------------------------------------------------------------
`default_nettype none
package tsf_pkg;

    localparam int NUM_TASKS = 16;
    localparam int IDX_W     = $clog2(NUM_TASKS);
    localparam int CNT_W     = $clog2(NUM_TASKS + 1);
    localparam int TIME_W    = 16;
    localparam int ID_W      = 4;
    localparam int PADDR_W   = 3;
    localparam int PDATA_W   = 32;

    // register byte addresses
    localparam logic [PADDR_W-1:0] REG_POLICY = PADDR_W'(0);

    typedef enum logic [1:0] {
        KIND_LOAD    = 2'd0,
        KIND_TICK    = 2'd1,
        KIND_RESTART = 2'd2,
        KIND_NONE    = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        POL_FCFS = 2'd0,
        POL_SPN  = 2'd1,
        POL_SRTN = 2'd2,
        POL_LLF  = 2'd3
    } t_policy;

    typedef enum logic [1:0] {
        ST_EMPTY = 2'd0,
        ST_READY = 2'd1,
        ST_DONE  = 2'd2,
        ST_DROP  = 2'd3
    } t_status;

    typedef enum logic {
        OUT_DONE = 1'b0,
        OUT_DROP = 1'b1
    } t_outcome;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_FIN,
        S_FLUSH,
        S_CLR
    } t_state;

    // one task table word
    typedef struct packed {
        logic [TIME_W-1:0] arrival;
        logic [TIME_W-1:0] service;
        logic [TIME_W-1:0] deadline;
        logic [TIME_W-1:0] remaining;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    // one report before the last flag is known
    typedef struct packed {
        logic [ID_W-1:0]   task_id;
        t_outcome          outcome;
        logic [TIME_W-1:0] wait_ticks;
        logic [TIME_W-1:0] turnaround_ticks;
    } t_rpt;

    // engine status seen by the top level
    typedef struct packed {
        logic busy;
        logic pend_v;
    } t_eng_stat;

endpackage
`default_nettype wire

FILE: src/tsf_if.sv
// ----------------------------------------------------------------------------
// tsf_if
// Valid/ready channels for task transactions and report transactions.
// ----------------------------------------------------------------------------
`default_nettype none
interface tsf_task_if;
    logic                          valid;
    logic                          ready;
    logic [1:0]                    kind;
    logic [3:0]                    entry_index;
    logic [tsf_pkg::TIME_W-1:0]    arrival;
    logic [tsf_pkg::TIME_W-1:0]    service;
    logic [tsf_pkg::TIME_W-1:0]    deadline;

    modport source  (output valid, kind, entry_index, arrival, service, deadline,
                     input ready);
    modport sink    (input valid, kind, entry_index, arrival, service, deadline,
                     output ready);
    // observe every signal, drive nothing
    modport monitor (input valid, ready, kind, entry_index, arrival, service, deadline);
endinterface

interface tsf_rpt_if;
    logic                          valid;
    logic                          ready;
    logic [3:0]                    task_id;
    logic                          outcome;
    logic [tsf_pkg::TIME_W-1:0]    wait_ticks;
    logic [tsf_pkg::TIME_W-1:0]    turnaround_ticks;
    logic                          last;

    modport source  (output valid, task_id, outcome, wait_ticks, turnaround_ticks, last,
                     input ready);
    modport sink    (input valid, task_id, outcome, wait_ticks, turnaround_ticks, last,
                     output ready);
    // observe every signal, drive nothing
    modport monitor (input valid, ready, task_id, outcome, wait_ticks, turnaround_ticks,
                     last);
endinterface
`default_nettype wire

FILE: src/tsf_ram.sv
// ----------------------------------------------------------------------------
// tsf_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none
module tsf_ram #(
    parameter  int WIDTH = 8,
    parameter  int DEPTH = 16,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output      logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read, data held while read enable is low
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule
`default_nettype wire

FILE: src/tsf_apb.sv
// ----------------------------------------------------------------------------
// tsf_apb
// APB-style configuration port holding the scheduling policy register.
// ----------------------------------------------------------------------------
`default_nettype none
module tsf_apb (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [tsf_pkg::PADDR_W-1:0]   paddr,
    input  wire logic [tsf_pkg::PDATA_W-1:0]   pwdata,
    output      logic [tsf_pkg::PDATA_W-1:0]   prdata,
    output      logic                          pready,
    output      tsf_pkg::t_policy              o_policy
);

    tsf_pkg::t_policy r_policy;
    tsf_pkg::t_policy n_policy;
    logic             sel_policy;

    // decode on the register index bit, ignore byte offset
    assign sel_policy = (paddr[tsf_pkg::PADDR_W-1] == tsf_pkg::REG_POLICY[tsf_pkg::PADDR_W-1]);

    // take a write on the access phase
    always_comb begin
        n_policy = r_policy;
        if (psel && penable && pwrite && sel_policy) begin
            n_policy = tsf_pkg::t_policy'(pwdata[1:0]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_policy <= tsf_pkg::POL_FCFS;
        end else begin
            r_policy <= n_policy;
        end
    end

    // read back
    always_comb begin
        prdata = '0;
        if (sel_policy) begin
            prdata = {{(tsf_pkg::PDATA_W-2){1'b0}}, r_policy};
        end
    end

    assign pready   = 1'b1;
    assign o_policy = r_policy;

endmodule
`default_nettype wire

FILE: src/tsf_engine.sv
// ----------------------------------------------------------------------------
// tsf_engine
// Task table sequencer: loads, restart sweep, per-tick slot scan and finish.
// ----------------------------------------------------------------------------
`default_nettype none
module tsf_engine (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  tsf_pkg::t_policy          i_policy,
    tsf_task_if.sink                  i_task,
    tsf_rpt_if.source                 o_rpt,
    output tsf_pkg::t_eng_stat        o_stat
);

    localparam int N  = tsf_pkg::NUM_TASKS;
    localparam int AW = tsf_pkg::IDX_W;
    localparam int CW = tsf_pkg::CNT_W;
    localparam int TW = tsf_pkg::TIME_W;

    // table memory
    logic                        ram_we;
    logic [AW-1:0]               ram_waddr;
    tsf_pkg::t_entry             ram_wdata;
    logic                        ram_re;
    logic [AW-1:0]               ram_raddr;
    logic [tsf_pkg::ENTRY_W-1:0] ram_rdata;

    tsf_ram #(
        .WIDTH (tsf_pkg::ENTRY_W),
        .DEPTH (N)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // control and state registers
    tsf_pkg::t_state   r_state,  n_state;
    tsf_pkg::t_status  r_status [N];
    tsf_pkg::t_status  n_status [N];
    logic [TW-1:0]     r_clock,  n_clock;
    logic              r_run_v,  n_run_v;
    logic [AW-1:0]     r_run_idx, n_run_idx;
    logic [CW-1:0]     r_ridx,   n_ridx;
    logic              r_ev,     n_ev;
    logic [AW-1:0]     r_eidx,   n_eidx;
    logic              r_found,  n_found;
    logic              r_keep,   n_keep;
    logic              r_pick_v, n_pick_v;
    logic [AW-1:0]     r_pidx,   n_pidx;
    tsf_pkg::t_entry   r_pw,     n_pw;
    logic [TW-1:0]     r_best,   n_best;
    logic              r_pend_v, n_pend_v;
    tsf_pkg::t_rpt     r_pend,   n_pend;
    logic              r_ov;
    tsf_pkg::t_rpt     r_out;
    logic              r_out_last;

    // push path into the output register
    logic              push;
    tsf_pkg::t_rpt     push_rpt;
    logic              push_last;
    logic              out_free;

    // slot evaluation
    tsf_pkg::t_entry   ev;
    logic              ev_ready;
    logic              ev_arr;
    logic              ev_late;
    logic [TW-1:0]     ev_key;
    logic              ev_pick;
    logic              ev_drop;
    logic [TW-1:0]     ev_best;
    logic              stall;

    // finish of a tick
    logic [TW-1:0]     rem1;
    logic [TW-1:0]     next_clk;
    logic [TW-1:0]     turn;
    logic [TW-1:0]     wait_t;
    logic              fin_done;
    logic              fin_hold;
    logic              run_v_a;
    logic [AW-1:0]     run_idx_a;

    logic              in_acc;
    logic              load_ok;
    logic [AW-1:0]     load_idx;
    logic              scan_end;

    assign out_free = !r_ov || o_rpt.ready;
    assign in_acc   = i_task.valid && i_task.ready;
    assign load_ok  = (32'(i_task.entry_index) < N);
    assign load_idx = AW'(i_task.entry_index);
    assign scan_end = !r_ev && (r_ridx == CW'(N));

    // evaluate the slot whose data sits on the read port
    always_comb begin
        ev       = tsf_pkg::t_entry'(ram_rdata);
        ev_ready = (r_status[r_eidx] == tsf_pkg::ST_READY);
        ev_arr   = (r_clock >= ev.arrival);
        ev_late  = ({1'b0, r_clock} + {1'b0, ev.remaining}) > {1'b0, ev.deadline};
        ev_key   = ev.deadline - ev.remaining;
        ev_pick  = 1'b0;
        ev_drop  = 1'b0;
        ev_best  = r_best;
        case (i_policy)
            tsf_pkg::POL_FCFS: begin
                ev_pick = !r_found && ev_ready && ev_arr;
            end
            tsf_pkg::POL_SPN: begin
                if (r_keep) begin
                    ev_pick = (r_eidx == r_run_idx);
                end else begin
                    ev_pick = ev_ready && ev_arr && (!r_pick_v || ev.service < r_best);
                    ev_best = ev.service;
                end
            end
            tsf_pkg::POL_SRTN: begin
                ev_pick = ev_ready && ev_arr && (!r_pick_v || ev.remaining < r_best);
                ev_best = ev.remaining;
            end
            default: begin
                ev_drop = ev_ready && ev_arr && ev_late;
                ev_pick = ev_ready && ev_arr && !ev_late && (!r_pick_v || ev_key < r_best);
                ev_best = ev_key;
            end
        endcase
        stall = (r_state == tsf_pkg::S_SCAN) && r_ev && ev_drop && r_pend_v && !out_free;
    end

    // finish arithmetic for the chosen slot
    always_comb begin
        rem1      = (r_pw.remaining == '0) ? '0 : r_pw.remaining - TW'(1);
        next_clk  = (r_clock == {TW{1'b1}}) ? r_clock : r_clock + TW'(1);
        turn      = next_clk - r_pw.arrival;
        wait_t    = (turn >= r_pw.service) ? turn - r_pw.service : '0;
        fin_done  = r_pick_v && (rem1 == '0);
        fin_hold  = fin_done && r_pend_v && !out_free;
        run_v_a   = r_run_v;
        run_idx_a = r_run_idx;
        if (i_policy == tsf_pkg::POL_SPN && !r_keep) begin
            run_v_a   = r_pick_v;
            run_idx_a = r_pidx;
        end
        if (fin_done && run_idx_a == r_pidx) begin
            run_v_a = 1'b0;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            tsf_pkg::S_IDLE: begin
                if (in_acc && i_task.kind == tsf_pkg::KIND_TICK) begin
                    n_state = tsf_pkg::S_SCAN;
                end else if (in_acc && i_task.kind == tsf_pkg::KIND_RESTART) begin
                    n_state = tsf_pkg::S_CLR;
                end
            end
            tsf_pkg::S_SCAN: begin
                if (scan_end) begin
                    n_state = tsf_pkg::S_FIN;
                end
            end
            tsf_pkg::S_FIN: begin
                if (!fin_hold) begin
                    n_state = tsf_pkg::S_FLUSH;
                end
            end
            tsf_pkg::S_FLUSH: begin
                if (!r_pend_v || out_free) begin
                    n_state = tsf_pkg::S_IDLE;
                end
            end
            tsf_pkg::S_CLR: begin
                if (scan_end) begin
                    n_state = tsf_pkg::S_IDLE;
                end
            end
            default: n_state = tsf_pkg::S_IDLE;
        endcase
    end

    // datapath and memory controls
    always_comb begin
        n_status  = r_status;
        n_clock   = r_clock;
        n_run_v   = r_run_v;
        n_run_idx = r_run_idx;
        n_ridx    = r_ridx;
        n_ev      = r_ev;
        n_eidx    = r_eidx;
        n_found   = r_found;
        n_keep    = r_keep;
        n_pick_v  = r_pick_v;
        n_pidx    = r_pidx;
        n_pw      = r_pw;
        n_best    = r_best;
        n_pend_v  = r_pend_v;
        n_pend    = r_pend;
        ram_we    = 1'b0;
        ram_waddr = r_eidx;
        ram_wdata = ev;
        ram_re    = 1'b0;
        ram_raddr = r_ridx[AW-1:0];
        push      = 1'b0;
        push_rpt  = r_pend;
        push_last = 1'b0;

        case (r_state)
            // take loads directly; arm a tick scan or a restart sweep
            tsf_pkg::S_IDLE: begin
                if (in_acc) begin
                    case (i_task.kind)
                        tsf_pkg::KIND_LOAD: begin
                            if (load_ok) begin
                                ram_we    = 1'b1;
                                ram_waddr = load_idx;
                                ram_wdata = '{arrival:   i_task.arrival,
                                              service:   i_task.service,
                                              deadline:  i_task.deadline,
                                              remaining: i_task.service};
                                n_status[load_idx] = tsf_pkg::ST_READY;
                                if (r_run_v && r_run_idx == load_idx) begin
                                    n_run_v = 1'b0;
                                end
                            end
                        end
                        tsf_pkg::KIND_TICK: begin
                            n_ridx   = '0;
                            n_ev     = 1'b0;
                            n_found  = 1'b0;
                            n_pick_v = 1'b0;
                            n_keep   = (i_policy == tsf_pkg::POL_SPN) && r_run_v &&
                                       (r_status[r_run_idx] == tsf_pkg::ST_READY);
                        end
                        tsf_pkg::KIND_RESTART: begin
                            for (int i = 0; i < N; i++) begin
                                if (r_status[i] != tsf_pkg::ST_EMPTY) begin
                                    n_status[i] = tsf_pkg::ST_READY;
                                end
                            end
                            n_clock = '0;
                            n_run_v = 1'b0;
                            n_ridx  = '0;
                            n_ev    = 1'b0;
                        end
                        default: begin
                        end
                    endcase
                end
            end

            // one slot per cycle; hold on a drop report that cannot move
            tsf_pkg::S_SCAN: begin
                if (!stall) begin
                    if (r_ev) begin
                        if (i_policy == tsf_pkg::POL_FCFS && ev_ready) begin
                            n_found = 1'b1;
                        end
                        if (ev_pick) begin
                            n_pick_v = 1'b1;
                            n_pidx   = r_eidx;
                            n_pw     = ev;
                            n_best   = ev_best;
                        end
                        if (ev_drop) begin
                            n_status[r_eidx] = tsf_pkg::ST_DROP;
                            if (r_run_v && r_run_idx == r_eidx) begin
                                n_run_v = 1'b0;
                            end
                            if (r_pend_v) begin
                                push = 1'b1;
                            end
                            n_pend_v = 1'b1;
                            n_pend   = '{task_id: tsf_pkg::ID_W'(r_eidx),
                                         outcome: tsf_pkg::OUT_DROP,
                                         wait_ticks: '0, turnaround_ticks: '0};
                        end
                    end
                    ram_re = (r_ridx != CW'(N));
                    n_ev   = ram_re;
                    n_eidx = r_ridx[AW-1:0];
                    n_ridx = r_ridx + CW'(ram_re);
                end
            end

            // charge the chosen slot and advance the clock
            tsf_pkg::S_FIN: begin
                if (!fin_hold) begin
                    n_clock   = next_clk;
                    n_run_v   = run_v_a;
                    n_run_idx = run_idx_a;
                    if (r_pick_v) begin
                        ram_we    = 1'b1;
                        ram_waddr = r_pidx;
                        ram_wdata = '{arrival:   r_pw.arrival,
                                      service:   r_pw.service,
                                      deadline:  r_pw.deadline,
                                      remaining: rem1};
                    end
                    if (fin_done) begin
                        n_status[r_pidx] = tsf_pkg::ST_DONE;
                        if (r_pend_v) begin
                            push = 1'b1;
                        end
                        n_pend_v = 1'b1;
                        n_pend   = '{task_id: tsf_pkg::ID_W'(r_pidx),
                                     outcome: tsf_pkg::OUT_DONE,
                                     wait_ticks: wait_t, turnaround_ticks: turn};
                    end
                end
            end

            // release the held report as the last one of this tick
            tsf_pkg::S_FLUSH: begin
                if (r_pend_v && out_free) begin
                    push      = 1'b1;
                    push_last = 1'b1;
                    n_pend_v  = 1'b0;
                end
            end

            // restart sweep: read a slot, write it back with full remaining time
            tsf_pkg::S_CLR: begin
                ram_re = (r_ridx != CW'(N));
                n_ev   = ram_re;
                n_eidx = r_ridx[AW-1:0];
                n_ridx = r_ridx + CW'(ram_re);
                if (r_ev) begin
                    ram_we    = 1'b1;
                    ram_waddr = r_eidx;
                    ram_wdata = '{arrival:   ev.arrival,
                                  service:   ev.service,
                                  deadline:  ev.deadline,
                                  remaining: ev.service};
                end
            end

            default: begin
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= tsf_pkg::S_IDLE;
            r_clock  <= '0;
            r_run_v  <= 1'b0;
            r_ev     <= 1'b0;
            r_pend_v <= 1'b0;
            r_ov     <= 1'b0;
            for (int i = 0; i < N; i++) begin
                r_status[i] <= tsf_pkg::ST_EMPTY;
            end
        end else begin
            r_state  <= n_state;
            r_clock  <= n_clock;
            r_run_v  <= n_run_v;
            r_ev     <= n_ev;
            r_pend_v <= n_pend_v;
            r_status <= n_status;
            if (push) begin
                r_ov <= 1'b1;
            end else if (o_rpt.ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    // payload and scan registers
    always_ff @(posedge i_clk) begin
        r_run_idx <= n_run_idx;
        r_ridx    <= n_ridx;
        r_eidx    <= n_eidx;
        r_found   <= n_found;
        r_keep    <= n_keep;
        r_pick_v  <= n_pick_v;
        r_pidx    <= n_pidx;
        r_pw      <= n_pw;
        r_best    <= n_best;
        r_pend    <= n_pend;
        if (push) begin
            r_out      <= push_rpt;
            r_out_last <= push_last;
        end
    end

    // ports
    assign i_task.ready           = (r_state == tsf_pkg::S_IDLE);
    assign o_rpt.valid            = r_ov;
    assign o_rpt.task_id          = r_out.task_id;
    assign o_rpt.outcome          = r_out.outcome;
    assign o_rpt.wait_ticks       = r_out.wait_ticks;
    assign o_rpt.turnaround_ticks = r_out.turnaround_ticks;
    assign o_rpt.last             = r_out_last;
    assign o_stat.busy            = (r_state != tsf_pkg::S_IDLE);
    assign o_stat.pend_v          = r_pend_v;

endmodule
`default_nettype wire

FILE: src/task_scheduler_four_policy_core.sv
// ----------------------------------------------------------------------------
// task_scheduler_four_policy_core
// Tick-driven task table scheduler with FCFS, SPN, SRTN and least-laxity.
// ----------------------------------------------------------------------------
//  channel   dir   handshake        payload
//  i_task    in    valid/ready      kind, entry_index, arrival, service, deadline
//  o_rpt     out   valid/ready      task_id, outcome, wait_ticks, turnaround_ticks, last
//  apb       in    psel/penable     policy register at byte address 0
//
//  A load is written directly from idle. A tick holds the input off after it is
//  accepted, through the scan (one table read per slot through the single read
//  port, plus fill and drain), the finish state and the flush state.
//  A restart sweeps the table.
//  A full report register that is not taken stretches a tick.
//  Reset clears the slot status, the clock, the running slot and the policy.
// ----------------------------------------------------------------------------
`default_nettype none
module task_scheduler_four_policy_core (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    tsf_task_if.sink                           i_task,
    tsf_rpt_if.source                          o_rpt,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [tsf_pkg::PADDR_W-1:0]   paddr,
    input  wire logic [tsf_pkg::PDATA_W-1:0]   pwdata,
    output      logic [tsf_pkg::PDATA_W-1:0]   prdata,
    output      logic                          pready
);

    tsf_pkg::t_policy   policy;
    tsf_pkg::t_eng_stat stat;

    // configuration register
    tsf_apb u_apb (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .o_policy (policy)
    );

    // scheduler engine
    tsf_engine u_engine (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_policy (policy),
        .i_task   (i_task),
        .o_rpt    (o_rpt),
        .o_stat   (stat)
    );

    // a tick transaction always starts a scan
    a_tick_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_task.valid && i_task.ready && i_task.kind == tsf_pkg::KIND_TICK) |=> stat.busy)
        else $error("tick accepted without starting a scan");

    // no report is left behind once the engine is idle
    a_idle_flushed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !stat.busy |-> !stat.pend_v)
        else $error("held report while idle");

    // dropped tasks carry no timing
    a_drop_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rpt.valid && o_rpt.outcome == tsf_pkg::OUT_DROP) |->
            (o_rpt.wait_ticks == '0 && o_rpt.turnaround_ticks == '0))
        else $error("drop report with nonzero timing");

endmodule
`default_nettype wire

FILE: verif/tsf_checker.sv
// ----------------------------------------------------------------------------
// tsf_checker
// Watches the task and report channels, predicts the scheduler's reports
// from its own copy of the task table and compares them in order.
// ----------------------------------------------------------------------------
`default_nettype none
module tsf_checker (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    tsf_task_if.monitor     i_task_mon,
    tsf_rpt_if.monitor      i_rpt_mon,
    input  wire logic [1:0] i_policy,
    output int              o_fail_count,
    output int              o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [3:0]                 task_id;
        logic                       outcome;
        logic [tsf_pkg::TIME_W-1:0] wait_ticks;
        logic [tsf_pkg::TIME_W-1:0] turnaround_ticks;
        logic                       last;
    } t_report;

    logic [tsf_pkg::TIME_W-1:0] arr_tbl [tsf_pkg::NUM_TASKS];
    logic [tsf_pkg::TIME_W-1:0] svc_tbl [tsf_pkg::NUM_TASKS];
    logic [tsf_pkg::TIME_W-1:0] dl_tbl  [tsf_pkg::NUM_TASKS];
    logic [tsf_pkg::TIME_W-1:0] rem_tbl [tsf_pkg::NUM_TASKS];
    tsf_pkg::t_status           stat_tbl[tsf_pkg::NUM_TASKS];
    logic [tsf_pkg::TIME_W-1:0] sched_clock;
    int                         run_slot;
    t_report                    expected_reports[$];

    assign o_pending = expected_reports.size();

    function automatic bit is_runnable(int i);
        return stat_tbl[i] == tsf_pkg::ST_READY && sched_clock >= arr_tbl[i];
    endfunction

    // Advance the scheduler model by one task transaction
    task automatic apply_task(logic [1:0] kind, logic [3:0] idx, logic [15:0] arr,
                              logic [15:0] svc, logic [15:0] dl);
        int      pick;
        longint  best;
        longint  key;
        int      nxt;
        int      turn;
        int      wt;
        int      first;
        t_report r;
        pick  = tsf_pkg::NUM_TASKS;
        best  = 64'h7FFF_FFFF_FFFF;
        first = expected_reports.size();
        case (tsf_pkg::t_kind'(kind))
            tsf_pkg::KIND_LOAD: begin
                arr_tbl[idx] = arr;
                svc_tbl[idx] = svc;
                dl_tbl[idx] = dl;
                rem_tbl[idx] = svc;
                stat_tbl[idx] = tsf_pkg::ST_READY;
                if (run_slot == idx) run_slot = tsf_pkg::NUM_TASKS;
            end
            tsf_pkg::KIND_RESTART: begin
                for (int i = 0; i < tsf_pkg::NUM_TASKS; i++) begin
                    if (stat_tbl[i] != tsf_pkg::ST_EMPTY) begin
                        stat_tbl[i] = tsf_pkg::ST_READY;
                        rem_tbl[i] = svc_tbl[i];
                    end
                end
                sched_clock = 0;
                run_slot = tsf_pkg::NUM_TASKS;
            end
            tsf_pkg::KIND_TICK: begin
                case (tsf_pkg::t_policy'(i_policy))
                    tsf_pkg::POL_FCFS: begin
                        for (int i = 0; i < tsf_pkg::NUM_TASKS; i++) begin
                            if (stat_tbl[i] == tsf_pkg::ST_READY) begin
                                if (sched_clock >= arr_tbl[i]) pick = i;
                                break;
                            end
                        end
                    end
                    tsf_pkg::POL_SPN: begin
                        if (run_slot < tsf_pkg::NUM_TASKS &&
                            stat_tbl[run_slot] == tsf_pkg::ST_READY) begin
                            pick = run_slot;
                        end else begin
                            for (int i = 0; i < tsf_pkg::NUM_TASKS; i++)
                                if (is_runnable(i) && svc_tbl[i] < best) begin
                                    best = svc_tbl[i];
                                    pick = i;
                                end
                            run_slot = pick;
                        end
                    end
                    tsf_pkg::POL_SRTN: begin
                        for (int i = 0; i < tsf_pkg::NUM_TASKS; i++)
                            if (is_runnable(i) && rem_tbl[i] < best) begin
                                best = rem_tbl[i];
                                pick = i;
                            end
                    end
                    default: begin
                        for (int i = 0; i < tsf_pkg::NUM_TASKS; i++) begin
                            if (!is_runnable(i)) continue;
                            if (int'(sched_clock) + int'(rem_tbl[i]) > int'(dl_tbl[i])) begin
                                stat_tbl[i] = tsf_pkg::ST_DROP;
                                if (run_slot == i) run_slot = tsf_pkg::NUM_TASKS;
                                r = '{i[3:0], tsf_pkg::OUT_DROP, '0, '0, 1'b0};
                                expected_reports.push_back(r);
                            end else begin
                                key = longint'(dl_tbl[i]) - longint'(rem_tbl[i]);
                                if (key < best) begin
                                    best = key;
                                    pick = i;
                                end
                            end
                        end
                    end
                endcase
                nxt = (sched_clock < 16'hFFFF) ? int'(sched_clock) + 1 : 16'hFFFF;
                if (pick < tsf_pkg::NUM_TASKS) begin
                    if (rem_tbl[pick] > 0) rem_tbl[pick]--;
                    if (rem_tbl[pick] == 0) begin
                        turn = nxt - int'(arr_tbl[pick]);
                        wt = (turn >= int'(svc_tbl[pick])) ? turn - int'(svc_tbl[pick]) : 0;
                        stat_tbl[pick] = tsf_pkg::ST_DONE;
                        if (run_slot == pick) run_slot = tsf_pkg::NUM_TASKS;
                        r = '{pick[3:0], tsf_pkg::OUT_DONE, wt[15:0], turn[15:0], 1'b0};
                        expected_reports.push_back(r);
                    end
                end
                sched_clock = nxt[15:0];
                // Flag the final report of this tick
                if (expected_reports.size() > first)
                    expected_reports[expected_reports.size()-1].last = 1'b1;
            end
            default: ;
        endcase
    endtask

    // Predict on accepted task transactions, compare on accepted reports
    always @(posedge i_clk) begin
        t_report exp_r;
        if (!i_rst_n) begin
            for (int i = 0; i < tsf_pkg::NUM_TASKS; i++) stat_tbl[i] = tsf_pkg::ST_EMPTY;
            sched_clock = 0;
            run_slot = tsf_pkg::NUM_TASKS;
            expected_reports.delete();
            o_fail_count = 0;
        end else begin
            if (i_rpt_mon.valid && i_rpt_mon.ready) begin
                if (expected_reports.size() == 0) begin
                    $error("unexpected report transaction, task_id %0d", i_rpt_mon.task_id);
                    o_fail_count++;
                end else begin
                    exp_r = expected_reports.pop_front();
                    if (i_rpt_mon.task_id !== exp_r.task_id) begin
                        $error("task_id exp %0d got %0d", exp_r.task_id, i_rpt_mon.task_id);
                        o_fail_count++;
                    end
                    if (i_rpt_mon.outcome !== exp_r.outcome) begin
                        $error("outcome exp %0d got %0d", exp_r.outcome, i_rpt_mon.outcome);
                        o_fail_count++;
                    end
                    if (i_rpt_mon.wait_ticks !== exp_r.wait_ticks) begin
                        $error("wait_ticks exp %0d got %0d", exp_r.wait_ticks,
                               i_rpt_mon.wait_ticks);
                        o_fail_count++;
                    end
                    if (i_rpt_mon.turnaround_ticks !== exp_r.turnaround_ticks) begin
                        $error("turnaround_ticks exp %0d got %0d", exp_r.turnaround_ticks,
                               i_rpt_mon.turnaround_ticks);
                        o_fail_count++;
                    end
                    if (i_rpt_mon.last !== exp_r.last) begin
                        $error("last exp %0d got %0d", exp_r.last, i_rpt_mon.last);
                        o_fail_count++;
                    end
                end
            end
            if (i_task_mon.valid && i_task_mon.ready)
                apply_task(i_task_mon.kind, i_task_mon.entry_index, i_task_mon.arrival,
                           i_task_mon.service, i_task_mon.deadline);
        end
    end
endmodule
`default_nettype wire

FILE: verif/tb_task_scheduler_four_policy_core.sv
// ----------------------------------------------------------------------------
// tb_task_scheduler_four_policy_core
// Drives task transactions under all four policies with random idling and
// report back-pressure; the checker predicts and compares every report.
// ----------------------------------------------------------------------------
`default_nettype none
module tb_task_scheduler_four_policy_core;
    timeunit 1ns;
    timeprecision 1ps;

    logic                        i_clk = 1'b0;
    logic                        i_rst_n = 1'b0;
    logic                        psel = 1'b0;
    logic                        penable = 1'b0;
    logic                        pwrite = 1'b0;
    logic [tsf_pkg::PADDR_W-1:0] paddr = '0;
    logic [tsf_pkg::PDATA_W-1:0] pwdata = '0;
    logic [tsf_pkg::PDATA_W-1:0] prdata;
    logic                        pready;
    logic [1:0]                  policy_shadow = tsf_pkg::POL_FCFS;
    int                          fail_count;
    int                          pending_reports;
    bit                          no_idle = 1'b0;
    bit                          hold_reports = 1'b0;

    tsf_task_if task_ch();
    tsf_rpt_if  rpt_ch();

    task_scheduler_four_policy_core DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_task(task_ch.sink), .o_rpt(rpt_ch.source),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    tsf_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_task_mon(task_ch.monitor),
        .i_rpt_mon(rpt_ch.monitor), .i_policy(policy_shadow),
        .o_fail_count(fail_count), .o_pending(pending_reports)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    initial begin
        #50ms;
        $display("tb: failure");
        $finish;
    end

    // Drain reports with random stalls; hold off entirely while asked
    initial begin
        rpt_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            rpt_ch.ready <= !hold_reports && (no_idle || $urandom_range(99) >= 28);
        end
    end

    // Long back-pressure stretch counted in cycles
    initial begin
        @(posedge i_rst_n);
        repeat (3000) @(posedge i_clk);
        @(negedge i_clk);
        hold_reports = 1'b1;
        repeat (400) @(negedge i_clk);
        hold_reports = 1'b0;
    end

    task automatic write_policy(logic [1:0] pol);
        @(negedge i_clk);
        psel <= 1'b1; pwrite <= 1'b1; paddr <= tsf_pkg::REG_POLICY;
        pwdata <= tsf_pkg::PDATA_W'(pol);
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        policy_shadow = pol;
        @(negedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    endtask

    // Wait for all reports plus the tick latency before touching the register
    task automatic settle();
        while (pending_reports != 0) @(posedge i_clk);
        repeat (3 * tsf_pkg::NUM_TASKS + 10) @(posedge i_clk);
    endtask

    // Offer one transaction, holding it until accepted
    task automatic send(tsf_pkg::t_kind kind, logic [3:0] idx = '0, logic [15:0] arr = '0,
                        logic [15:0] svc = 16'd1, logic [15:0] dl = '0);
        while (!no_idle && $urandom_range(99) < 28) begin
            task_ch.valid = 1'b0;
            @(negedge i_clk);
        end
        task_ch.valid = 1'b1;
        task_ch.kind <= kind;
        task_ch.entry_index <= idx;
        task_ch.arrival <= arr;
        task_ch.service <= svc;
        task_ch.deadline <= dl;
        do @(posedge i_clk); while (!task_ch.ready);
        @(negedge i_clk);
        task_ch.valid = 1'b0;
    endtask

    task automatic load_rand(logic [3:0] idx);
        logic [15:0] svc;
        logic [15:0] arr;
        svc = ($urandom_range(15) == 0) ? 16'($urandom_range(65535, 1))
                                        : 16'($urandom_range(6, 1));
        arr = ($urandom_range(15) == 0) ? 16'($urandom) : 16'($urandom_range(12));
        send(tsf_pkg::KIND_LOAD, idx, arr, svc, 16'(arr + svc + $urandom_range(20)));
    endtask

    initial begin
        task_ch.valid = 1'b0;
        task_ch.kind = tsf_pkg::KIND_NONE;
        task_ch.entry_index = '0;
        task_ch.arrival = '0;
        task_ch.service = '0;
        task_ch.deadline = '0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: field extremes, kinds, drops and zero-ish cases
        write_policy(tsf_pkg::POL_LLF);
        send(tsf_pkg::KIND_LOAD, 4'd0, 16'd0, 16'd1, 16'd0);
        send(tsf_pkg::KIND_LOAD, 4'd15, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send(tsf_pkg::KIND_LOAD, 4'd5, 16'd0, 16'd2, 16'd10);
        send(tsf_pkg::KIND_LOAD, 4'd10, 16'd1, 16'd3, 16'd1);
        send(tsf_pkg::KIND_NONE, 4'd7, 16'h5555, 16'hAAAA, 16'h1234);
        repeat (5) send(tsf_pkg::KIND_TICK);
        send(tsf_pkg::KIND_RESTART);
        repeat (4) send(tsf_pkg::KIND_TICK);
        settle();
        write_policy(tsf_pkg::POL_FCFS);
        send(tsf_pkg::KIND_LOAD, 4'd0, 16'd3, 16'd2, 16'd0);
        send(tsf_pkg::KIND_LOAD, 4'd1, 16'd0, 16'd1, 16'd0);
        repeat (6) send(tsf_pkg::KIND_TICK);
        settle();

        // Random phases over each policy
        for (int ph = 0; ph < 8; ph++) begin
            write_policy(ph < 4 ? 2'(ph) : 2'($urandom_range(3)));
            no_idle = (ph == 2);
            send(tsf_pkg::KIND_RESTART);
            for (int n = 0; n < 53; n++) begin
                case ($urandom_range(9))
                    0, 1:    load_rand(4'($urandom));
                    2:       if ($urandom_range(7) == 0) send(tsf_pkg::KIND_RESTART);
                             else send(tsf_pkg::KIND_NONE, 4'($urandom), 16'($urandom),
                                       16'($urandom), 16'($urandom));
                    default: send(tsf_pkg::KIND_TICK);
                endcase
            end
            settle();
        end

        // Far-future arrival under SRTN: the task stays waiting, no reports
        write_policy(tsf_pkg::POL_SRTN);
        send(tsf_pkg::KIND_RESTART);
        send(tsf_pkg::KIND_LOAD, 4'd3, 16'hFFFE, 16'h0004, 16'hFFFF);
        no_idle = 1'b1;
        repeat (8) send(tsf_pkg::KIND_TICK);
        no_idle = 1'b0;
        settle();

        if (fail_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end
endmodule
`default_nettype wire
